>>> rtl/core/f2p16_pkg.sv
// Package with binary32 field widths and PCM conversion constants.
package f2p16_pkg;
   localparam int unsigned SampleWidth = 32;
   localparam int unsigned PcmWidth    = 16;
   localparam int unsigned MantWidth   = 24;
   localparam int unsigned ProdWidth   = 39;
   localparam logic [7:0]  ExpMax      = 8'hFF;
   localparam logic [7:0]  ExpOne      = 8'd127;
   localparam logic [7:0]  ExpMinLive  = 8'd111;
   localparam logic [7:0]  ExpBias     = 8'd150;
   localparam logic [14:0] PcmScale    = 15'd32767;
   localparam logic signed [15:0] PcmFull = 16'sd32767;
endpackage

>>> rtl/core/float_to_pcm16_converter.sv
// Top level: binary32 audio sample to 16-bit PCM converter.
//
// Input channel req_*: one raw binary32 sample per transaction on
// req_sample_bits. Result channel rsp_*: one signed PCM value per
// transaction on rsp_pcm_value.
// NaN gives 0; everything else is clamped to [-1, 1], scaled by 32767 with
// single-precision round-to-nearest-even, then rounded half away from zero.
// The result is registered: the accepting edge loads it and sets rsp_valid.
// Throughput: one transaction per cycle while the receiver does not hold
// rsp_stall, set by the single result register that holds the scaled and rounded value.
// req_stall is high only while a result waits in the result register and
// the receiver holds rsp_stall; the held result does not change then.
// Reset (synchronous, active high) empties the result register; there is
// no other state.
module float_to_pcm16_converter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [f2p16_pkg::SampleWidth-1:0]    req_sample_bits,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [f2p16_pkg::PcmWidth-1:0] rsp_pcm_value
);
   import f2p16_pkg::*;

   logic                         sign;
   logic [7:0]                   expo;
   logic [22:0]                  frac;
   logic                         is_nan;
   logic [7:0]                   e_c;
   logic [MantWidth-1:0]         mant;
   logic [ProdWidth-1:0]         prod;
   logic [MantWidth-1:0]         keep;
   logic                         guard;
   logic                         sticky;
   logic [MantWidth:0]           rnd;
   logic [7:0]                   k;
   logic [7:0]                   n;
   logic [4:0]                   sh;
   logic [MantWidth:0]           t;
   logic [MantWidth:0]           mag;
   logic signed [PcmWidth-1:0]   pcm;
   logic                         accept;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [PcmWidth-1:0]   rsp_pcm_ff, rsp_pcm_in;

   always_comb begin
      sign   = req_sample_bits[31];
      expo   = req_sample_bits[30:23];
      frac   = req_sample_bits[22:0];
      is_nan = (expo == ExpMax) && (frac != 23'd0);
      // clamp magnitudes above one (infinities too) to exactly one
      if (expo >= ExpOne) begin
         e_c  = ExpOne;
         mant = {1'b1, 23'd0};
      end else begin
         e_c  = expo;
         mant = {(expo != 8'd0), frac};
      end
      prod = {15'd0, mant} * {24'd0, PcmScale};
      // round the exact product to 24 bits, nearest even
      if (prod[ProdWidth-1]) begin
         keep   = prod[38:15];
         guard  = prod[14];
         sticky = |prod[13:0];
         k      = 8'd15;
      end else begin
         keep   = prod[37:14];
         guard  = prod[13];
         sticky = |prod[12:0];
         k      = 8'd14;
      end
      rnd = {1'b0, keep} + {{MantWidth{1'b0}}, guard & (sticky | keep[0])};
      n   = ExpBias - k - e_c;
      sh  = 5'(n - 8'd1);
      t   = rnd >> sh;
      mag = (t + {{MantWidth{1'b0}}, 1'b1}) >> 1;
      if (is_nan || (e_c < ExpMinLive)) begin
         pcm = '0;
      end else if (sign) begin
         pcm = -$signed(mag[PcmWidth-1:0]);
      end else begin
         pcm = $signed(mag[PcmWidth-1:0]);
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pcm_in   = rsp_pcm_ff;
      if (!req_stall) begin
         rsp_valid_in = req_valid;
      end
      if (accept) begin
         rsp_pcm_in = pcm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pcm_ff <= rsp_pcm_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pcm_value = rsp_pcm_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result register not emptied by reset");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pcm_value <= PcmFull) && (rsp_pcm_value >= -PcmFull))
      else $error("pcm value out of range");
   a_nan_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && is_nan) |=> (rsp_valid && rsp_pcm_value == 16'sd0))
      else $error("NaN did not give silence");
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction lost");
endmodule
